// File: sv/sia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg: shared types and microcode for the signed integer ALU
// Word width, micro-op and jump-condition codes, control word layout,
// the microprogram ROM and the operation dispatch table.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int UA_W  = 4;

    typedef logic [UA_W-1:0] uaddr_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // datapath micro-ops
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ADD,
        ACT_SUB,
        ACT_MUL_INIT,
        ACT_MUL_STEP,
        ACT_MUL_FIX,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_DIV_FIX,
        ACT_CLEAR,
        ACT_EMIT
    } act_t;

    // jump conditions: true takes tgt, false takes nxt; dispatch takes the per-operation entry
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_ITEM,
        COND_DISPATCH,
        COND_CNT_NZ,
        COND_B_ZERO,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t   act;
        cond_t  cond;
        uaddr_t tgt;
        uaddr_t nxt;
        logic   cnt_load;
    } uword_t;

    // status from datapath to sequencer
    typedef struct packed {
        op_t  op;
        logic b_zero;
    } status_t;

    // microprogram addresses
    localparam uaddr_t UA_FETCH    = 4'd0;
    localparam uaddr_t UA_DISPATCH = 4'd1;
    localparam uaddr_t UA_ADD      = 4'd2;
    localparam uaddr_t UA_SUB      = 4'd3;
    localparam uaddr_t UA_MUL_INIT = 4'd4;
    localparam uaddr_t UA_MUL_STEP = 4'd5;
    localparam uaddr_t UA_MUL_FIX  = 4'd6;
    localparam uaddr_t UA_DIV_INIT = 4'd7;
    localparam uaddr_t UA_DIV_STEP = 4'd8;
    localparam uaddr_t UA_DIV_FIX  = 4'd9;
    localparam uaddr_t UA_DIV_ZERO = 4'd10;
    localparam uaddr_t UA_FINISH   = 4'd11;
    localparam uaddr_t UA_LAST     = UA_FINISH;

    // microprogram ROM
    function automatic uword_t urom(input uaddr_t addr);
        uword_t w;
        w = '{act: ACT_NONE, cond: COND_NEVER, tgt: UA_FETCH, nxt: UA_FETCH,
              cnt_load: 1'b0};
        unique case (addr)
            UA_FETCH:
                w = '{act: ACT_LOAD, cond: COND_NO_ITEM, tgt: UA_FETCH,
                      nxt: UA_DISPATCH, cnt_load: 1'b0};
            UA_DISPATCH:
                w = '{act: ACT_NONE, cond: COND_DISPATCH, tgt: UA_FETCH,
                      nxt: UA_FETCH, cnt_load: 1'b0};
            UA_ADD:
                w = '{act: ACT_ADD, cond: COND_NEVER, tgt: UA_FINISH,
                      nxt: UA_FINISH, cnt_load: 1'b0};
            UA_SUB:
                w = '{act: ACT_SUB, cond: COND_NEVER, tgt: UA_FINISH,
                      nxt: UA_FINISH, cnt_load: 1'b0};
            UA_MUL_INIT:
                w = '{act: ACT_MUL_INIT, cond: COND_NEVER, tgt: UA_MUL_STEP,
                      nxt: UA_MUL_STEP, cnt_load: 1'b1};
            UA_MUL_STEP:
                w = '{act: ACT_MUL_STEP, cond: COND_CNT_NZ, tgt: UA_MUL_STEP,
                      nxt: UA_MUL_FIX, cnt_load: 1'b0};
            UA_MUL_FIX:
                w = '{act: ACT_MUL_FIX, cond: COND_NEVER, tgt: UA_FINISH,
                      nxt: UA_FINISH, cnt_load: 1'b0};
            UA_DIV_INIT:
                w = '{act: ACT_DIV_INIT, cond: COND_B_ZERO, tgt: UA_DIV_ZERO,
                      nxt: UA_DIV_STEP, cnt_load: 1'b1};
            UA_DIV_STEP:
                w = '{act: ACT_DIV_STEP, cond: COND_CNT_NZ, tgt: UA_DIV_STEP,
                      nxt: UA_DIV_FIX, cnt_load: 1'b0};
            UA_DIV_FIX:
                w = '{act: ACT_DIV_FIX, cond: COND_NEVER, tgt: UA_FINISH,
                      nxt: UA_FINISH, cnt_load: 1'b0};
            UA_DIV_ZERO:
                w = '{act: ACT_CLEAR, cond: COND_NEVER, tgt: UA_FINISH,
                      nxt: UA_FINISH, cnt_load: 1'b0};
            UA_FINISH:
                w = '{act: ACT_EMIT, cond: COND_OUT_BUSY, tgt: UA_FINISH,
                      nxt: UA_FETCH, cnt_load: 1'b0};
            default:
                w = '{act: ACT_NONE, cond: COND_NEVER, tgt: UA_FETCH,
                      nxt: UA_FETCH, cnt_load: 1'b0};
        endcase
        return w;
    endfunction

    // entry point per operation
    function automatic uaddr_t dispatch_addr(input op_t op);
        uaddr_t a;
        a = UA_ADD;
        unique case (op)
            OP_ADD:  a = UA_ADD;
            OP_SUB:  a = UA_SUB;
            OP_MUL:  a = UA_MUL_INIT;
            OP_DIV:  a = UA_DIV_INIT;
            default: a = UA_ADD;
        endcase
        return a;
    endfunction

endpackage

// File: sv/signed_int_alu_add_sub_mul_div_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_alu_add_sub_mul_div_top: microcoded signed integer ALU
// Add, subtract, multiply (shift-add) and divide (restoring) on signed
// 32-bit words, one result item per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with operation, operand_a, operand_b.
//   Output channel: out_valid / out_stall with result.
//   One item is in the datapath at a time; in_stall is low only while the
//   sequencer sits at its fetch step.
//   Multiply and a divide by a nonzero divisor run 32 bit steps on the
//   shared datapath; the sequencer is back at fetch the cycle after it
//   writes the result. The bit steps come from the one-bit-per-cycle
//   shift-add and shift-subtract loops run by the microprogram's step
//   counter; a divide by zero skips the loop and gives a zero result.
//   The result sits in an output register, so the next item is accepted as
//   soon as the result is written, even while out_stall holds it.
//   If out_stall holds a previous result when the next one is ready, the
//   sequencer waits at its finish step.
//   Reset clears the micro-PC to fetch and drops out_valid.
// ----------------------------------------------------------------------------
module signed_int_alu_add_sub_mul_div_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic signed [sia_pkg::WIDTH-1:0]  operand_a,
    input  logic signed [sia_pkg::WIDTH-1:0]  operand_b,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sia_pkg::WIDTH-1:0]  result
);
    import sia_pkg::*;

    act_t             act;
    status_t          status;
    logic [WIDTH-1:0] acc;
    logic             emit;
    logic             out_busy;

    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] result_reg, result_next;

    assign out_busy = out_valid_reg && out_stall;

    sia_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .status   (status),
        .act      (act),
        .in_stall (in_stall),
        .emit     (emit)
    );

    sia_datapath u_dp (
        .clk       (clk),
        .act       (act),
        .operation (operation),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .status    (status),
        .acc       (acc)
    );

    // output register
    always_comb
    begin
        out_valid_next = emit ? 1'b1 : out_busy;
        result_next    = emit ? acc : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = $signed(result_reg);

    // a result is only written into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && out_stall))
        else $error("result written over a held item");

    // input is never taken while a result is being written
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> in_stall)
        else $error("item accepted during result write");

    // every new result follows a write by the sequencer
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("out_valid rose without a result write");

endmodule

// File: sv/sia_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_sequencer: microprogram sequencer
// Micro-PC, step counter and ROM lookup; picks the next address from the
// control word's condition and drives the datapath micro-op.
// ----------------------------------------------------------------------------
module sia_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_busy,
    input  sia_pkg::status_t status,
    output sia_pkg::act_t    act,
    output logic             in_stall,
    output logic             emit
);
    import sia_pkg::*;

    uaddr_t           upc_reg, upc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    uword_t           uw;
    logic             take;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_FETCH;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    // control word decode and next address
    always_comb
    begin
        uw   = urom(upc_reg);
        take = 1'b0;
        unique case (uw.cond)
            COND_NEVER:    take = 1'b0;
            COND_NO_ITEM:  take = !in_valid;
            COND_DISPATCH: take = 1'b1;
            COND_CNT_NZ:   take = (cnt_reg != '0);
            COND_B_ZERO:   take = status.b_zero;
            COND_OUT_BUSY: take = out_busy;
            default:       take = 1'b0;
        endcase

        if (uw.cond == COND_DISPATCH)
            upc_next = dispatch_addr(status.op);
        else
            upc_next = take ? uw.tgt : uw.nxt;

        // step counter: one pass per bit
        if (uw.cnt_load)
            cnt_next = CNT_W'(WIDTH - 1);
        else if (uw.cond == COND_CNT_NZ && cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;

        act      = uw.act;
        in_stall = (upc_reg != UA_FETCH);
        emit     = (uw.act == ACT_EMIT) && !out_busy;
    end

    // an accepted item goes straight to dispatch
    a_fetch_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (upc_reg == UA_DISPATCH))
        else $error("accepted item did not reach dispatch");

    // bit loops leave to the sign fixup once the counter runs out
    a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_MUL_STEP && cnt_reg == '0) |=> (upc_reg == UA_MUL_FIX))
        else $error("multiply loop did not terminate");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_DIV_STEP && cnt_reg == '0) |=> (upc_reg == UA_DIV_FIX))
        else $error("divide loop did not terminate");

    // micro-PC stays inside the program
    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= UA_LAST)
        else $error("micro-PC left the program");

endmodule

// File: sv/sia_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_datapath: operand registers, adder and shift logic
// Shared registers serve add/sub, shift-add multiply and restoring divide;
// each micro-op performs one step.
// ----------------------------------------------------------------------------
module sia_datapath (
    input  logic                              clk,
    input  sia_pkg::act_t                     act,
    input  logic [1:0]                        operation,
    input  logic signed [sia_pkg::WIDTH-1:0]  operand_a,
    input  logic signed [sia_pkg::WIDTH-1:0]  operand_b,
    output sia_pkg::status_t                  status,
    output logic [sia_pkg::WIDTH-1:0]         acc
);
    import sia_pkg::*;

    // opa: addend / dividend bits, opb: multiplier bits / divisor
    logic [WIDTH-1:0] opa_reg, opa_next;
    logic [WIDTH-1:0] opb_reg, opb_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    op_t              op_reg, op_next;
    logic             sign_a_reg, sign_a_next;
    logic             sign_b_reg, sign_b_next;

    logic [WIDTH-1:0] rem_sh;
    logic [WIDTH:0]   diff;

    always_ff @(posedge clk)
    begin
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        op_reg     <= op_next;
        sign_a_reg <= sign_a_next;
        sign_b_reg <= sign_b_next;
    end

    // one micro-op per cycle
    always_comb
    begin
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        op_next     = op_reg;
        sign_a_next = sign_a_reg;
        sign_b_next = sign_b_reg;

        // restoring divide trial subtract
        rem_sh = {rem_reg[WIDTH-2:0], opa_reg[WIDTH-1]};
        diff   = {1'b0, rem_sh} - {1'b0, opb_reg};

        unique case (act)
            ACT_NONE, ACT_EMIT:
            begin
            end
            ACT_LOAD:
            begin
                opa_next    = $unsigned(operand_a);
                opb_next    = $unsigned(operand_b);
                op_next     = op_t'(operation);
                sign_a_next = operand_a[WIDTH-1];
                sign_b_next = operand_b[WIDTH-1];
            end
            ACT_ADD:
                acc_next = opa_reg + opb_reg;
            ACT_SUB:
                acc_next = opa_reg - opb_reg;
            ACT_MUL_INIT:
            begin
                opb_next = sign_b_reg ? (~opb_reg + 1'b1) : opb_reg;
                acc_next = '0;
            end
            ACT_MUL_STEP:
            begin
                if (opb_reg[0])
                    acc_next = acc_reg + opa_reg;
                opa_next = {opa_reg[WIDTH-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[WIDTH-1:1]};
            end
            ACT_MUL_FIX:
                acc_next = sign_b_reg ? (~acc_reg + 1'b1) : acc_reg;
            ACT_DIV_INIT:
            begin
                opa_next = sign_a_reg ? (~opa_reg + 1'b1) : opa_reg;
                opb_next = sign_b_reg ? (~opb_reg + 1'b1) : opb_reg;
                rem_next = '0;
                acc_next = '0;
            end
            ACT_DIV_STEP:
            begin
                // no borrow: keep the difference, quotient bit is one
                if (!diff[WIDTH])
                begin
                    rem_next = diff[WIDTH-1:0];
                    acc_next = {acc_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    acc_next = {acc_reg[WIDTH-2:0], 1'b0};
                end
                opa_next = {opa_reg[WIDTH-2:0], 1'b0};
            end
            ACT_DIV_FIX:
                acc_next = (sign_a_reg ^ sign_b_reg) ? (~acc_reg + 1'b1) : acc_reg;
            ACT_CLEAR:
                acc_next = '0;
            default:
            begin
            end
        endcase
    end

    assign status.op     = op_reg;
    assign status.b_zero = (opb_reg == '0);
    assign acc           = acc_reg;

endmodule

// File: dv/signed_int_alu_add_sub_mul_div_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_alu_add_sub_mul_div_top_tb: self-checking bench for the ALU
// Drives a directed table of corner operands, then random operations with
// random operand classes, under random input gaps, random output stalls and one long
// output hold-off. Each result item is checked against a local bit-exact
// model of the shift-add multiply and restoring divide, or against a typed
// value for the obvious corner rows.
// ----------------------------------------------------------------------------
module signed_int_alu_add_sub_mul_div_top_tb;

    import sia_pkg::*;

    localparam int          W           = WIDTH;
    localparam logic [W-1:0] WORD_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] WORD_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_NEG1  = {W{1'b1}};
    localparam int          RAND_ITEMS  = 450;
    localparam int          HOLD_CYCLES = 300;
    localparam int          IDLE_PCT    = 18;
    localparam int          STUCK_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 60;
    localparam int          MAX_REPORTS = 10;

    typedef struct {
        op_t          op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic         typed;
        logic [W-1:0] res;
    } alu_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          operation;
    logic signed [W-1:0] operand_a;
    logic signed [W-1:0] operand_b;
    logic                out_valid;
    logic                out_stall;
    logic signed [W-1:0] result;

    logic [W-1:0] pending_results[$];
    alu_row_t     corner_rows[23];
    int           error_count;
    int           stuck_cycles;
    logic         quiet;
    logic         hold_armed;

    signed_int_alu_add_sub_mul_div_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // two's-complement helpers at the word width
    function automatic logic [W-1:0] negate_word(input logic [W-1:0] x);
        return ~x + 1'b1;
    endfunction

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] x);
        return x[W-1] ? negate_word(x) : x;
    endfunction

    // expected ALU output: wrap add/sub, shift-add multiply, restoring divide
    function automatic logic [W-1:0] alu_expect(input op_t op, input logic [W-1:0] a,
                                                input logic [W-1:0] b);
        logic [W-1:0] mult_bits;
        logic [W-1:0] acc;
        logic [W-1:0] addend;
        logic [W:0]   rem;
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        logic [W-1:0] quot;
        acc = '0;
        case (op)
            OP_ADD: acc = a + b;
            OP_SUB: acc = a - b;
            OP_MUL:
            begin
                mult_bits = magnitude(b);
                addend    = a;
                for (int i = 0; i < W; i++)
                begin
                    if (mult_bits[0])
                        acc = acc + addend;
                    addend    = addend << 1;
                    mult_bits = mult_bits >> 1;
                end
                if (b[W-1])
                    acc = negate_word(acc);
            end
            default:
            begin
                if (b != '0)
                begin
                    dividend = magnitude(a);
                    divisor  = magnitude(b);
                    rem      = '0;
                    quot     = '0;
                    for (int i = W - 1; i >= 0; i--)
                    begin
                        rem = {rem[W-1:0], dividend[i]};
                        if (rem >= {1'b0, divisor})
                        begin
                            rem     = rem - {1'b0, divisor};
                            quot[i] = 1'b1;
                        end
                    end
                    acc = (a[W-1] ^ b[W-1]) ? negate_word(quot) : quot;
                end
            end
        endcase
        return acc;
    endfunction

    // operand classes: zero, one, minus one, extremes, small, full random
    function automatic logic [W-1:0] pick_operand();
        logic [W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = 1;
            2: v = WORD_NEG1;
            3: v = WORD_MIN;
            4: v = WORD_MAX;
            5, 6:
            begin
                v = $urandom_range(300);
                if ($urandom_range(1))
                    v = negate_word(v);
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // present one item, hold it until accepted, record the expected result
    task automatic send_item(input op_t op, input logic [W-1:0] a, input logic [W-1:0] b,
                             input logic typed, input logic [W-1:0] typed_res);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(typed ? typed_res : alu_expect(op, a, b));
        @(negedge clk);
    endtask

    // result receiver: random stalls, one long hold-off once random items start
    initial
    begin
        int hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        logic [W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result item: got 0x%08h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("result error: expected 0x%08h (%0d) got 0x%08h (%0d)",
                                 want, $signed(want), result, result);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("signed_int_alu_add_sub_mul_div_top: mismatch");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        op_t          rop;
        logic [W-1:0] ra;
        logic [W-1:0] rb;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_ADD;
        operand_a    = '0;
        operand_b    = '0;
        error_count  = 0;
        stuck_cycles = 0;
        quiet        = 1'b0;
        hold_armed   = 1'b0;

        corner_rows = '{
            // wrap on add and subtract
            '{OP_ADD, WORD_MAX,  1,         1'b1, WORD_MIN},
            '{OP_ADD, WORD_MIN,  WORD_MIN,  1'b1, '0},
            '{OP_ADD, WORD_NEG1, 1,         1'b1, '0},
            '{OP_SUB, WORD_MIN,  1,         1'b1, WORD_MAX},
            '{OP_SUB, '0,        WORD_MIN,  1'b1, WORD_MIN},
            '{OP_SUB, 5,         9,         1'b1, -32'sd4},
            // multiply, including by the minimum value
            '{OP_MUL, WORD_MIN,  WORD_MIN,  1'b1, '0},
            '{OP_MUL, 3,         WORD_MIN,  1'b1, WORD_MIN},
            '{OP_MUL, WORD_MAX,  WORD_MAX,  1'b1, 1},
            '{OP_MUL, WORD_NEG1, WORD_NEG1, 1'b1, 1},
            '{OP_MUL, 12345,     -32'sd678, 1'b0, '0},
            '{OP_MUL, '0,        WORD_MAX,  1'b1, '0},
            // divide by zero, min by min, min by minus one, truncation
            '{OP_DIV, 5,         '0,        1'b1, '0},
            '{OP_DIV, WORD_MIN,  '0,        1'b1, '0},
            '{OP_DIV, WORD_MIN,  WORD_MIN,  1'b1, 1},
            '{OP_DIV, WORD_MIN,  WORD_NEG1, 1'b1, WORD_MIN},
            '{OP_DIV, -32'sd7,   2,         1'b1, -32'sd3},
            '{OP_DIV, 7,         -32'sd2,   1'b1, -32'sd3},
            '{OP_DIV, -32'sd7,   -32'sd2,   1'b1, 3},
            '{OP_DIV, WORD_MAX,  1,         1'b1, WORD_MAX},
            '{OP_DIV, 1,         WORD_MAX,  1'b1, '0},
            '{OP_DIV, WORD_MIN,  7,         1'b0, '0},
            '{OP_DIV, WORD_MAX,  WORD_MIN,  1'b1, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners
        foreach (corner_rows[i])
            send_item(corner_rows[i].op, corner_rows[i].a, corner_rows[i].b,
                      corner_rows[i].typed, corner_rows[i].res);

        // random items; the receiver holds off once at the start
        hold_armed <= 1'b1;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            quiet = (n >= 150 && n < 250);
            rop   = op_t'($urandom_range(3));
            ra    = pick_operand();
            rb    = pick_operand();
            send_item(rop, ra, rb, 1'b0, '0);
        end
        quiet    = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("signed_int_alu_add_sub_mul_div_top: match");
        else
            $display("signed_int_alu_add_sub_mul_div_top: mismatch");
        $finish;
    end

endmodule

// File: signed_int_alu_add_sub_mul_div_top.f
sv/sia_pkg.sv
sv/sia_sequencer.sv
sv/sia_datapath.sv
sv/signed_int_alu_add_sub_mul_div_top.sv
dv/signed_int_alu_add_sub_mul_div_top_tb.sv
